// ===== rtl/dc_pkg.sv =====
// Shared types and constants of the divisor counter.
// Holds the controller/datapath command and status records and the factor codes.
// Depends on nothing; every other file of the block imports it.
package dc_pkg;

	localparam int DC_N_WIDTH = 40;
	localparam int DC_OUT_W   = 13;
	localparam logic [DC_OUT_W-1:0] DC_OUT_MAX = '1;

	typedef enum logic [1:0] {
		FAC_E     = 2'd0,
		FAC_TWO   = 2'd1,
		FAC_THREE = 2'd2,
		FAC_FOUR  = 2'd3
	} fac_t;

	typedef struct packed {
		logic load;
		logic div_start;
		logic take_quot;
		logic next_d;
		logic mul_en;
		fac_t fac;
		logic publish;
	} dc_cmd_t;

	typedef struct packed {
		logic cube_le;
		logic sq_le;
		logic m_gt_one;
		logic div_done;
		logic rem_zero;
		logic quot_eq_d;
	} dc_sts_t;

endpackage

// ===== rtl/dc_if.sv =====
// Valid/ready channel interfaces of the divisor counter: request and result.
// Depends on dc_pkg for the default value width and the result width.
interface dc_req_if import dc_pkg::*; #(
	parameter int N_WIDTH = DC_N_WIDTH
);
	logic               valid;
	logic               ready;
	logic [N_WIDTH-1:0] n_value;

	modport source (output valid, output n_value, input ready);
	modport sink (input valid, input n_value, output ready);
endinterface

interface dc_rsp_if import dc_pkg::*;;
	logic                valid;
	logic                ready;
	logic [DC_OUT_W-1:0] divisor_count;
	logic [DC_OUT_W-1:0] count_less_one;

	modport source (output valid, output divisor_count, output count_less_one, input ready);
	modport sink (input valid, input divisor_count, input count_less_one, output ready);
endinterface

// ===== rtl/dc_div.sv =====
// Restoring divider of the divisor counter, one quotient bit per cycle.
// Depends on dc_pkg; instantiated by the datapath dc_dp.
module dc_div import dc_pkg::*; #(
	parameter int N_WIDTH = DC_N_WIDTH
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [N_WIDTH-1:0] dividend,
	input  logic [N_WIDTH-1:0] divisor,
	output logic               done,
	output logic [N_WIDTH-1:0] quotient,
	output logic               rem_zero
);
	localparam int CW = $clog2(N_WIDTH + 1);

	logic [N_WIDTH-1:0] rem_q;
	logic [N_WIDTH-1:0] quo_q;
	logic [CW-1:0]      cnt_q;
	logic               busy_q;
	logic               done_q;
	logic [N_WIDTH:0]   trial;
	logic [N_WIDTH:0]   diff;
	logic               ge;

	assign trial = {rem_q, quo_q[N_WIDTH-1]};
	assign ge    = trial >= {1'b0, divisor};
	assign diff  = trial - {1'b0, divisor};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(N_WIDTH);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
		end else if (busy_q) begin
			rem_q <= ge ? diff[N_WIDTH-1:0] : trial[N_WIDTH-1:0];
			quo_q <= {quo_q[N_WIDTH-2:0], ge};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;
	assign rem_zero = rem_q == '0;

endmodule

// ===== rtl/dc_dp.sv =====
// Datapath of the divisor counter: shrinking value, trial divisor with its square
// and cube, running count and result register. Depends on dc_pkg and dc_div.
module dc_dp import dc_pkg::*; #(
	parameter int N_WIDTH = DC_N_WIDTH
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic [N_WIDTH-1:0]  n_value,
	input  dc_cmd_t             cmd,
	output dc_sts_t             sts,
	output logic [DC_OUT_W-1:0] divisor_count,
	output logic [DC_OUT_W-1:0] count_less_one
);
	localparam int SW = N_WIDTH + 2;
	localparam int EW = $clog2(N_WIDTH + 1);
	localparam int PW = DC_OUT_W + EW;

	logic [N_WIDTH-1:0]  m_q;
	logic [N_WIDTH-1:0]  d_q;
	logic [SW-1:0]       sq_q;
	logic [SW-1:0]       cube_q;
	logic [DC_OUT_W-1:0] total_q;
	logic                sat_q;
	logic [EW-1:0]       e_q;
	logic [DC_OUT_W-1:0] count_q;
	logic [DC_OUT_W-1:0] less_q;

	logic [N_WIDTH-1:0]  quotient;
	logic                div_done;
	logic                rem_zero;
	logic                d_is_two;
	logic [N_WIDTH-1:0]  d_next;
	logic [SW-1:0]       sq_next;
	logic [SW-1:0]       cube_next;
	logic [EW-1:0]       fac_val;
	logic [PW-1:0]       prod;
	logic                prod_big;

	dc_div #(.N_WIDTH(N_WIDTH)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (m_q),
		.divisor  (d_q),
		.done     (div_done),
		.quotient (quotient),
		.rem_zero (rem_zero)
	);

	// Stepping the divisor by two (from 2 it steps to 3): (d+2)^2 = d^2 + 4d + 4, (d+2)^3 = d^3 + 6d^2 + 12d + 8.
	assign d_is_two  = d_q == N_WIDTH'(2);
	assign d_next    = d_is_two ? N_WIDTH'(3) : d_q + N_WIDTH'(2);
	assign sq_next   = d_is_two ? SW'(9) : sq_q + {d_q, 2'b00} + SW'(4);
	assign cube_next = d_is_two ? SW'(27) :
		cube_q + {sq_q[SW-3:0], 2'b00} + {sq_q[SW-2:0], 1'b0} +
		SW'({d_q, 3'b000}) + {d_q, 2'b00} + SW'(8);

	always_comb begin
		case (cmd.fac)
			FAC_E:     fac_val = e_q;
			FAC_TWO:   fac_val = EW'(2);
			FAC_THREE: fac_val = EW'(3);
			FAC_FOUR:  fac_val = EW'(4);
			default:   fac_val = EW'(1);
		endcase
	end

	assign prod     = PW'(total_q) * PW'(fac_val);
	assign prod_big = prod > PW'(DC_OUT_MAX);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			m_q     <= n_value;
			d_q     <= N_WIDTH'(2);
			sq_q    <= SW'(4);
			cube_q  <= SW'(8);
			total_q <= DC_OUT_W'(1);
			sat_q   <= 1'b0;
			e_q     <= EW'(1);
		end else begin
			if (cmd.take_quot) begin
				m_q <= quotient;
				e_q <= e_q + EW'(1);
			end
			if (cmd.next_d) begin
				d_q    <= d_next;
				sq_q   <= sq_next;
				cube_q <= cube_next;
				e_q    <= EW'(1);
			end
			if (cmd.mul_en) begin
				total_q <= prod_big ? DC_OUT_MAX : prod[DC_OUT_W-1:0];
				sat_q   <= sat_q | prod_big;
			end
		end
		if (cmd.publish) begin
			if (m_q == '0) begin
				count_q <= '0;
				less_q  <= '0;
			end else if (sat_q) begin
				count_q <= DC_OUT_MAX;
				less_q  <= DC_OUT_MAX;
			end else begin
				count_q <= total_q;
				less_q  <= total_q - DC_OUT_W'(1);
			end
		end
	end

	assign sts.cube_le   = cube_q <= SW'(m_q);
	assign sts.sq_le     = sq_q <= SW'(m_q);
	assign sts.m_gt_one  = m_q > N_WIDTH'(1);
	assign sts.div_done  = div_done;
	assign sts.rem_zero  = rem_zero;
	assign sts.quot_eq_d = quotient == d_q;

	assign divisor_count  = count_q;
	assign count_less_one = less_q;

endmodule

// ===== rtl/dc_ctrl.sv =====
// Controller of the divisor counter: sequences factor stripping, the leftover
// test and the result hand-off. Depends on dc_pkg.
module dc_ctrl import dc_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_ready,
	output logic    out_valid,
	input  logic    out_ready,
	input  dc_sts_t sts,
	output dc_cmd_t cmd
);
	typedef enum logic [7:0] {
		ST_IDLE = 8'b0000_0001,
		ST_CHKA = 8'b0000_0010,
		ST_SA   = 8'b0000_0100,
		ST_DIVA = 8'b0000_1000,
		ST_CHKB = 8'b0001_0000,
		ST_SB   = 8'b0010_0000,
		ST_DIVB = 8'b0100_0000,
		ST_FIN  = 8'b1000_0000
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   out_valid_q;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		cmd.fac = FAC_E;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_CHKA;
				end
			end
			ST_CHKA: begin
				state_d = sts.cube_le ? ST_SA : ST_CHKB;
			end
			ST_SA: begin
				cmd.div_start = 1'b1;
				state_d       = ST_DIVA;
			end
			ST_DIVA: begin
				if (sts.div_done) begin
					if (sts.rem_zero) begin
						cmd.take_quot = 1'b1;
						state_d       = ST_SA;
					end else begin
						cmd.mul_en = 1'b1;
						cmd.fac    = FAC_E;
						cmd.next_d = 1'b1;
						state_d    = ST_CHKA;
					end
				end
			end
			ST_CHKB: begin
				if (sts.sq_le) begin
					state_d = ST_SB;
				end else begin
					cmd.mul_en = sts.m_gt_one;
					cmd.fac    = FAC_TWO;
					state_d    = ST_FIN;
				end
			end
			ST_SB: begin
				cmd.div_start = 1'b1;
				state_d       = ST_DIVB;
			end
			ST_DIVB: begin
				if (sts.div_done) begin
					if (sts.rem_zero) begin
						cmd.mul_en = 1'b1;
						cmd.fac    = sts.quot_eq_d ? FAC_THREE : FAC_FOUR;
						state_d    = ST_FIN;
					end else begin
						cmd.next_d = 1'b1;
						state_d    = ST_CHKB;
					end
				end
			end
			ST_FIN: begin
				if (!out_valid_q || out_ready) begin
					cmd.publish = 1'b1;
					state_d     = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.publish) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign in_ready  = state_q == ST_IDLE;
	assign out_valid = out_valid_q;

endmodule

// ===== rtl/divisor_counter.sv =====
// Top level of the divisor counter: joins the controller and the datapath.
// Depends on dc_pkg, dc_if, dc_ctrl and dc_dp.
//
//   channel  direction  fields                          role
//   req      sink       n_value[N_WIDTH-1:0]            value whose divisors are counted
//   rsp      source     divisor_count, count_less_one   13-bit count and count minus one
//
// One item is worked at a time. A division runs in the shared one-bit-per-cycle divider,
// and each new trial divisor first has its bound checked. An item steps through trial
// divisors up to the cube root and up to the square root of the leftover, with one
// division per trial divisor and per prime factor stripped. The result register holds
// a finished item while the next one is accepted; a result not yet taken holds the
// following item in its last state. Reset is asynchronous and clears only control state.
module divisor_counter import dc_pkg::*; #(
	parameter int N_WIDTH = DC_N_WIDTH
) (
	input logic     clk,
	input logic     arst_n,
	dc_req_if.sink  req,
	dc_rsp_if.source rsp
);
	dc_cmd_t cmd;
	dc_sts_t sts;

	dc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.in_ready  (req.ready),
		.out_valid (rsp.valid),
		.out_ready (rsp.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	dc_dp #(.N_WIDTH(N_WIDTH)) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.n_value        (req.n_value),
		.cmd            (cmd),
		.sts            (sts),
		.divisor_count  (rsp.divisor_count),
		.count_less_one (rsp.count_less_one)
	);

endmodule

// ===== rtl/dc_checker.sv =====
// Port-level checks of the divisor counter, bound to the top level.
// Depends on dc_pkg and on the port names of divisor_counter.
module dc_checker import dc_pkg::*; #(
	parameter int N_WIDTH = DC_N_WIDTH
) (
	input logic                clk,
	input logic                arst_n,
	input logic                req_valid,
	input logic                req_ready,
	input logic [N_WIDTH-1:0]  req_n_value,
	input logic                rsp_valid,
	input logic                rsp_ready,
	input logic [DC_OUT_W-1:0] rsp_divisor_count,
	input logic [DC_OUT_W-1:0] rsp_count_less_one
);

	// A result that is not taken stays offered.
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid)
		else $error("result item withdrawn before it was taken");

	// A stalled result keeps its fields.
	a_rsp_stable: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> $stable(rsp_divisor_count) && $stable(rsp_count_less_one))
		else $error("result item changed while stalled");

	// The two result fields agree: zero, saturated, or one apart.
	a_rsp_pair: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (rsp_divisor_count == '0 && rsp_count_less_one == '0) ||
			(rsp_divisor_count == DC_OUT_MAX && rsp_count_less_one == DC_OUT_MAX) ||
			(rsp_count_less_one == rsp_divisor_count - DC_OUT_W'(1)))
		else $error("divisor count and count less one disagree");

	// An accepted item occupies the block for at least the next cycle.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("new item accepted straight after another");

	// A waiting request item keeps its value.
	a_req_stable: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_ready |=> $stable(req_n_value))
		else $error("request item changed while waiting");

endmodule

bind divisor_counter dc_checker #(.N_WIDTH(N_WIDTH)) u_dc_checker (
	.clk                (clk),
	.arst_n             (arst_n),
	.req_valid          (req.valid),
	.req_ready          (req.ready),
	.req_n_value        (req.n_value),
	.rsp_valid          (rsp.valid),
	.rsp_ready          (rsp.ready),
	.rsp_divisor_count  (rsp.divisor_count),
	.rsp_count_less_one (rsp.count_less_one)
);

// ===== test/divisor_counter_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench of divisor_counter: directed and random values with random idling.
// Depends on dc_pkg, the channel interfaces of dc_if and the divisor_counter top level.
module divisor_counter_tb;
	import dc_pkg::*;

	typedef struct {
		logic [DC_N_WIDTH-1:0] value;
		int unsigned           gap;
		bit                    drain;
	} stim_t;

	typedef struct {
		logic [DC_N_WIDTH-1:0] n_value;
		logic [DC_OUT_W-1:0]   divisor_count;
		logic [DC_OUT_W-1:0]   count_less_one;
	} count_t;

	localparam longint unsigned N_MAX = (64'd1 << DC_N_WIDTH) - 64'd1;

	logic clk;
	logic arst_n;

	dc_req_if #(.N_WIDTH(DC_N_WIDTH)) req_ch ();
	dc_rsp_if rsp_ch ();

	divisor_counter #(.N_WIDTH(DC_N_WIDTH)) i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	stim_t  pending_items[$];
	count_t expected_counts[$];

	int unsigned     source_burst = 0;
	int unsigned     sink_burst = 0;
	int unsigned     stall_cycles = 0;
	int unsigned     hold_cycles = 0;
	int              error_count = 0;
	longint unsigned cycle_count = 0;
	longint unsigned cycle_limit = 64'd5000;

	longint unsigned small_primes [6] = '{2, 3, 5, 7, 11, 13};
	longint unsigned directed_values [22] = '{
		1, 0, 2, 3, 4, 5, 6, 8, 9, 12, 36, 10201, 10403, 65521, 30030, 999983,
		1000000, 2036162, 64'h80_0000_0000, 64'hFF_FFFF_FFFF, 64'd963761198400, 1048576
	};

	always begin
		clk = 1'b1;
		#1;
		clk = 1'b0;
		#1;
	end

	// Counts divisors by stripping factors up to the cube root and classifying the leftover.
	// The number of trial divisions is returned as well, to size the run-time limit.
	function automatic count_t predict_count(input logic [DC_N_WIDTH-1:0] value,
			output int unsigned steps);
		count_t          res;
		longint unsigned m;
		longint unsigned total;
		longint unsigned d;
		longint unsigned e;
		longint unsigned r;
		longint unsigned probe;
		bit              is_prime;
		int              b;
		steps = 0;
		m = value;
		if (m == 0) begin
			total = 0;
		end else if (m == 1) begin
			total = 1;
		end else begin
			total = 1;
			d = 2;
			while (d * d * d <= m) begin
				e = 1;
				steps++;
				while (m % d == 0) begin
					m = m / d;
					e++;
					steps++;
				end
				total = total * e;
				d = (d == 2) ? 3 : d + 2;
			end
			is_prime = (m >= 2);
			if (m >= 4 && m % 2 == 0)
				is_prime = 1'b0;
			for (probe = 3; is_prime && m >= 4 && probe * probe <= m; probe += 2) begin
				steps++;
				if (m % probe == 0)
					is_prime = 1'b0;
			end
			if (is_prime) begin
				total = total * 2;
			end else if (m != 1) begin
				r = 0;
				for (b = 31; b >= 0; b--) begin
					probe = r | (64'd1 << b);
					if (probe * probe <= m)
						r = probe;
				end
				total = (r * r == m) ? total * 3 : total * 4;
			end
		end
		res.n_value = value;
		res.divisor_count = (total > DC_OUT_MAX) ? DC_OUT_MAX : total[DC_OUT_W-1:0];
		if (total == 0)
			res.count_less_one = '0;
		else if (total - 1 > DC_OUT_MAX)
			res.count_less_one = DC_OUT_MAX;
		else
			res.count_less_one = total[DC_OUT_W-1:0] - 1'b1;
		return res;
	endfunction

	task automatic note_error(input string msg);
		error_count++;
		if (error_count <= 10)
			$display("%s", msg);
	endtask

	task automatic queue_value(input logic [DC_N_WIDTH-1:0] value, input bit drain);
		stim_t       item;
		int unsigned steps;
		item.value = value;
		item.drain = drain;
		if (source_burst != 0) begin
			source_burst--;
			item.gap = 0;
		end else begin
			if ($urandom_range(0, 9) == 0)
				source_burst = $urandom_range(5, 20);
			item.gap = $urandom_range(0, 15);
		end
		void'(predict_count(value, steps));
		cycle_limit += longint'(steps + 16) * (DC_N_WIDTH + 3) * 4 + 64;
		pending_items.push_back(item);
	endtask

	always @(posedge clk or negedge arst_n) begin : stimulus_driver
		stim_t       next_item;
		count_t      want;
		int unsigned steps;
		logic        drive_valid;
		if (!arst_n) begin
			req_ch.valid <= 1'b0;
			req_ch.n_value <= '0;
			hold_cycles = 0;
		end else begin
			drive_valid = req_ch.valid;
			if (req_ch.valid && req_ch.ready) begin
				want = predict_count(req_ch.n_value, steps);
				expected_counts.push_back(want);
				drive_valid = 1'b0;
			end
			if (!drive_valid && pending_items.size() != 0) begin
				if (pending_items[0].drain && expected_counts.size() != 0) begin
					hold_cycles = 0;
				end else if (hold_cycles < pending_items[0].gap) begin
					hold_cycles++;
				end else begin
					next_item = pending_items.pop_front();
					req_ch.n_value <= next_item.value;
					drive_valid = 1'b1;
					hold_cycles = 0;
				end
			end
			req_ch.valid <= drive_valid;
		end
	end

	always @(posedge clk or negedge arst_n) begin : result_monitor
		count_t want;
		if (!arst_n) begin
			rsp_ch.ready <= 1'b0;
			stall_cycles = 0;
		end else begin
			if (rsp_ch.valid && rsp_ch.ready) begin
				if (expected_counts.size() == 0) begin
					note_error($sformatf("unexpected result: divisor_count %0d, count_less_one %0d",
						rsp_ch.divisor_count, rsp_ch.count_less_one));
				end else begin
					want = expected_counts.pop_front();
					if (rsp_ch.divisor_count !== want.divisor_count)
						note_error($sformatf("n_value %0d: divisor_count expected %0d, got %0d",
							want.n_value, want.divisor_count, rsp_ch.divisor_count));
					if (rsp_ch.count_less_one !== want.count_less_one)
						note_error($sformatf("n_value %0d: count_less_one expected %0d, got %0d",
							want.n_value, want.count_less_one, rsp_ch.count_less_one));
				end
				if (sink_burst != 0) begin
					sink_burst--;
					stall_cycles = 0;
				end else begin
					if ($urandom_range(0, 9) == 0)
						sink_burst = $urandom_range(5, 20);
					stall_cycles = $urandom_range(0, 15);
				end
			end else if (stall_cycles != 0) begin
				stall_cycles--;
			end
			rsp_ch.ready <= (stall_cycles == 0);
		end
	end

	always @(posedge clk) begin : watchdog
		cycle_count++;
		if (cycle_count > cycle_limit) begin
			$display("[divisor_counter] ERROR");
			$finish;
		end
	end

	initial begin : sequencer
		longint unsigned v;
		int unsigned     i;
		int unsigned     k;
		int unsigned     kind;
		arst_n = 1'b0;

		foreach (directed_values[i])
			queue_value(directed_values[i][DC_N_WIDTH-1:0], 1'b0);

		// Mostly small values, so that the trial divisions stay short; large values are built
		// from small factors or by shifting, which keeps the leftover small.
		for (i = 0; i < 78; i++) begin
			kind = $urandom_range(0, 99);
			if (kind < 35) begin
				v = $urandom_range(0, 4095);
			end else if (kind < 60) begin
				v = $urandom_range(1, 65535);
			end else if (kind < 85) begin
				v = longint'($urandom_range(1, 65535)) << $urandom_range(0, 24);
			end else begin
				v = $urandom_range(1, 255);
				for (k = 0; k < 12; k++) begin
					if (v * small_primes[$urandom_range(0, 5)] <= N_MAX)
						v = v * small_primes[$urandom_range(0, 5)];
				end
				if (v > N_MAX)
					v = v >> 4;
			end
			queue_value(v[DC_N_WIDTH-1:0], (i == 0) || ($urandom_range(0, 39) == 0));
		end

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (pending_items.size() != 0 || req_ch.valid || expected_counts.size() != 0)
			@(posedge clk);
		repeat (4 * (DC_N_WIDTH + 3)) @(posedge clk);

		if (expected_counts.size() != 0)
			note_error($sformatf("%0d results never arrived", expected_counts.size()));
		if (error_count == 0)
			$display("[divisor_counter] OK");
		else
			$display("[divisor_counter] ERROR");
		$finish;
	end
endmodule

// ===== divisor_counter.f =====
rtl/dc_pkg.sv
rtl/dc_if.sv
rtl/dc_div.sv
rtl/dc_dp.sv
rtl/dc_ctrl.sv
rtl/divisor_counter.sv
rtl/dc_checker.sv
test/divisor_counter_tb.sv
